// ===== rtl/core/gbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and constants of the biconnectivity checker.
// ----------------------------------------------------------------------------
package gbc_pkg;

   localparam int END_W    = 10;  // endpoint field width
   localparam int VC_W     = 11;  // vertex count register width
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CAP   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LD_A,
      ST_LD_B,
      ST_CHK_INIT,
      ST_HEAD,
      ST_SCAN,
      ST_ENT,
      ST_VTX,
      ST_POP,
      ST_POPV,
      ST_FIN_RD,
      ST_FIN_REC,
      ST_FIN_PAR,
      ST_RESULT
   } state_type;

endpackage

// ===== rtl/core/graph_biconnectivity_check.sv =====
// ----------------------------------------------------------------------------
// graph_biconnectivity_check
// Loads an undirected graph edge by edge, then runs a depth-first low-point
// walk from vertex 0 and reports connectivity and 2-vertex-connectivity.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken at a clock edge with start high and busy
//   low. Each carries an optional edge (req_edge_valid, req_end_a, req_end_b)
//   and req_last, which closes the graph and starts the check.
//   Each stored edge is written as two adjacency inserts in turn, as both
//   need the single head-table write port; dropped edges and empty items
//   make no insert. The check walks the graph on memories with one read and
//   one write port, reading the vertex of each adjacency entry unless it is
//   not below the count (an entry that leads to a new vertex is visited again
//   on return), then sweeps the vertices for articulation points. The result
//   is shown for one cycle on rsp_* with rsp_valid high; the receiver cannot
//   stall it. After each result, and after reset, a clearing pass over all
//   MAX_VERTICES entries empties the adjacency heads and visit marks; busy
//   stays high while it runs. Configuration (csr_write_en, csr_vertex_count)
//   is taken at any edge, change it idle only.
// ----------------------------------------------------------------------------
module graph_biconnectivity_check
   import gbc_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int MAX_EDGES    = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_edge_valid,
   input  logic [END_W-1:0]    req_end_a,
   input  logic [END_W-1:0]    req_end_b,
   input  logic                req_last,
   output logic                rsp_valid,
   output logic                rsp_connected,
   output logic                rsp_biconnected,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_write_en,
   input  logic [VC_W-1:0]     csr_vertex_count
);

   localparam int ES = 2 * MAX_EDGES;          // adjacency entries
   localparam int VW = $clog2(MAX_VERTICES);   // vertex index
   localparam int CW = $clog2(MAX_VERTICES + 1); // vertex count
   localparam int EW = $clog2(ES);             // entry index
   localparam int PW = $clog2(ES + 1);         // entry pointer, 0 = end
   localparam int TW = $clog2(MAX_EDGES + 1);  // edge count

   typedef struct packed {
      logic          vis;
      logic [VW-1:0] ord;
      logic [VW-1:0] low;  // visit order of the low point
      logic [VW-1:0] par;
   } vtx_rec_type;

   typedef struct packed {
      logic [VW-1:0] tgt;
      logic [PW-1:0] nxt;
   } ent_rec_type;

   typedef struct packed {
      logic [VW-1:0] v;
      logic [PW-1:0] c;
   } frame_type;

   // memories
   logic [PW-1:0] head_mem [MAX_VERTICES];
   ent_rec_type   ent_mem  [ES];
   vtx_rec_type   vtx_mem  [MAX_VERTICES];
   frame_type     stk_mem  [MAX_VERTICES];

   logic [PW-1:0] head_q_ff;
   ent_rec_type   ent_q_ff;
   vtx_rec_type   vtx_q_ff;
   frame_type     stk_q_ff;

   // memory controls
   logic          head_re, head_we;
   logic [VW-1:0] head_raddr, head_waddr;
   logic [PW-1:0] head_wdata, head_rd;
   logic          ent_we;
   logic [EW-1:0] ent_raddr, ent_waddr;
   ent_rec_type   ent_wdata;
   logic          vtx_we;
   logic [VW-1:0] vtx_raddr, vtx_waddr;
   vtx_rec_type   vtx_wdata;
   logic          stk_we;
   logic [VW-1:0] stk_raddr, stk_waddr;
   frame_type     stk_wdata;

   // registers
   state_type          state_ff, state_in;
   logic [VC_W-1:0]    vc_ff;
   logic [TW-1:0]      total_ff, total_in;
   logic [STATUS_W-1:0] drop_ff, drop_in;
   logic [VW-1:0]      clr_idx_ff, clr_idx_in;
   logic               ld_last_ff, ld_last_in;
   logic [VW-1:0]      ld_a_ff, ld_a_in, ld_b_ff, ld_b_in;
   logic [VW-1:0]      cur_v_ff, cur_v_in;
   logic [PW-1:0]      cur_c_ff, cur_c_in;
   logic [VW-1:0]      cur_ord_ff, cur_ord_in;
   logic [VW-1:0]      cur_low_ff, cur_low_in;
   logic [VW-1:0]      cur_par_ff, cur_par_in;
   logic [VW-1:0]      sp_ff, sp_in;
   logic [CW-1:0]      order_ff, order_in;
   logic [CW-1:0]      seen_ff, seen_in;
   logic [VW-1:0]      u_ff, u_in;
   logic [PW-1:0]      nx_ff, nx_in;
   logic [CW-1:0]      fin_i_ff, fin_i_in;
   logic [VW-1:0]      fin_low_ff, fin_low_in;
   logic               kid_ff, kid_in;
   logic               conn_ff, conn_in;
   logic               bic_ff, bic_in;
   logic               fwd_hit_ff;
   logic [PW-1:0]      fwd_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_conn_ff, rsp_bic_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   // request decode
   logic          accept, busy_c;
   logic [CW-1:0] n_eff;
   logic          a_out, do_ins;
   logic [VW-1:0] new_low;
   logic          low_upd;

   // effective vertex count: zero acts as one, clamp to capacity
   always_comb begin
      if (vc_ff == '0) begin
         n_eff = CW'(1);
      end else if (32'(vc_ff) > 32'(MAX_VERTICES)) begin
         n_eff = CW'(MAX_VERTICES);
      end else begin
         n_eff = CW'(vc_ff);
      end
   end

   assign busy_c = !((state_ff == ST_IDLE) || ((state_ff == ST_LD_B) && !ld_last_ff));
   assign busy   = busy_c;
   assign accept = start && !busy_c;

   assign a_out  = (32'(req_end_a) >= 32'(n_eff)) || (32'(req_end_b) >= 32'(n_eff));
   assign do_ins = req_edge_valid && !a_out && (req_end_a != req_end_b)
                   && (32'(total_ff) < 32'(MAX_EDGES));

   // head read data with bypass of a write to the same entry in the read cycle
   assign head_rd = fwd_hit_ff ? fwd_data_ff : head_q_ff;

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = do_ins ? ST_LD_A : (req_last ? ST_CHK_INIT : ST_IDLE);
            end
         end
         ST_CLEAR: begin
            if (32'(clr_idx_ff) == 32'(MAX_VERTICES - 1)) state_in = ST_IDLE;
         end
         ST_LD_A: state_in = ST_LD_B;
         ST_LD_B: begin
            if (ld_last_ff) begin
               state_in = ST_CHK_INIT;
            end else if (accept) begin
               state_in = do_ins ? ST_LD_A : (req_last ? ST_CHK_INIT : ST_IDLE);
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CHK_INIT: state_in = ST_HEAD;
         ST_HEAD:     state_in = ST_SCAN;
         ST_SCAN: begin
            if (cur_c_ff != '0) begin
               state_in = ST_ENT;
            end else if (sp_ff == '0) begin
               state_in = ST_FIN_RD;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_ENT: begin
            state_in = (CW'(ent_q_ff.tgt) < n_eff) ? ST_VTX : ST_SCAN;
         end
         ST_VTX:  state_in = vtx_q_ff.vis ? ST_SCAN : ST_HEAD;
         ST_POP:  state_in = ST_POPV;
         ST_POPV: state_in = ST_SCAN;
         ST_FIN_RD: begin
            state_in = (!bic_ff || (fin_i_ff >= n_eff)) ? ST_RESULT : ST_FIN_REC;
         end
         ST_FIN_REC: state_in = (vtx_q_ff.par == '0) ? ST_FIN_RD : ST_FIN_PAR;
         ST_FIN_PAR: state_in = ST_FIN_RD;
         ST_RESULT:  state_in = ST_CLEAR;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---- datapath and memory controls ----
   always_comb begin
      head_re    = 1'b0;
      head_we    = 1'b0;
      head_raddr = '0;
      head_waddr = '0;
      head_wdata = '0;
      ent_we     = 1'b0;
      ent_raddr  = EW'(cur_c_ff - PW'(1));
      ent_waddr  = '0;
      ent_wdata  = '0;
      vtx_we     = 1'b0;
      vtx_raddr  = '0;
      vtx_waddr  = '0;
      vtx_wdata  = '0;
      stk_we     = 1'b0;
      stk_raddr  = '0;
      stk_waddr  = sp_ff;
      stk_wdata  = '0;

      total_in   = total_ff;
      drop_in    = drop_ff;
      clr_idx_in = clr_idx_ff;
      ld_last_in = ld_last_ff;
      ld_a_in    = ld_a_ff;
      ld_b_in    = ld_b_ff;
      cur_v_in   = cur_v_ff;
      cur_c_in   = cur_c_ff;
      cur_ord_in = cur_ord_ff;
      cur_low_in = cur_low_ff;
      cur_par_in = cur_par_ff;
      sp_in      = sp_ff;
      order_in   = order_ff;
      seen_in    = seen_ff;
      u_in       = u_ff;
      nx_in      = nx_ff;
      fin_i_in   = fin_i_ff;
      fin_low_in = fin_low_ff;
      kid_in     = kid_ff;
      conn_in    = conn_ff;
      bic_in     = bic_ff;
      rsp_valid_in = 1'b0;
      new_low    = cur_low_ff;
      low_upd    = 1'b0;

      // new transaction: note drops and start the first head read
      if (accept) begin
         head_re    = 1'b1;
         head_raddr = VW'(req_end_a);
         ld_a_in    = VW'(req_end_a);
         ld_b_in    = VW'(req_end_b);
         ld_last_in = req_last;
         if (req_edge_valid) begin
            if (a_out) begin
               drop_in = STATUS_RANGE;
            end else if (req_end_a != req_end_b && !do_ins && drop_ff == STATUS_OK) begin
               drop_in = STATUS_CAP;
            end
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_idx_ff;
            head_wdata = '0;
            vtx_we     = 1'b1;
            vtx_waddr  = clr_idx_ff;
            vtx_wdata  = '0;
            clr_idx_in = clr_idx_ff + VW'(1);
         end
         ST_LD_A: begin
            ent_we     = 1'b1;
            ent_waddr  = EW'({total_ff, 1'b0});
            ent_wdata  = '{tgt: ld_b_ff, nxt: head_rd};
            head_we    = 1'b1;
            head_waddr = ld_a_ff;
            head_wdata = PW'({total_ff, 1'b0}) + PW'(1);
            head_re    = 1'b1;
            head_raddr = ld_b_ff;
            total_in   = total_ff + TW'(1);
         end
         ST_LD_B: begin
            ent_we     = 1'b1;
            ent_waddr  = EW'({total_ff, 1'b0} - 1'b1);
            ent_wdata  = '{tgt: ld_a_ff, nxt: head_rd};
            head_we    = 1'b1;
            head_waddr = ld_b_ff;
            head_wdata = PW'({total_ff, 1'b0});
         end
         ST_CHK_INIT: begin
            vtx_we     = 1'b1;
            vtx_waddr  = '0;
            vtx_wdata  = '{vis: 1'b1, ord: '0, low: '0, par: '0};
            cur_v_in   = '0;
            cur_ord_in = '0;
            cur_low_in = '0;
            cur_par_in = '0;
            order_in   = CW'(1);
            seen_in    = CW'(1);
            sp_in      = '0;
            head_re    = 1'b1;
            head_raddr = '0;
         end
         ST_HEAD: begin
            cur_c_in = head_rd;
         end
         ST_SCAN: begin
            if (cur_c_ff == '0) begin
               if (sp_ff == '0) begin
                  // walk done: start the articulation sweep at vertex 1
                  conn_in  = (seen_ff == n_eff);
                  bic_in   = (seen_ff == n_eff);
                  fin_i_in = CW'(1);
                  kid_in   = 1'b0;
               end else begin
                  stk_raddr = sp_ff - VW'(1);
                  sp_in     = sp_ff - VW'(1);
               end
            end
         end
         ST_ENT: begin
            u_in  = ent_q_ff.tgt;
            nx_in = ent_q_ff.nxt;
            vtx_raddr = ent_q_ff.tgt;
            if (!(CW'(ent_q_ff.tgt) < n_eff)) cur_c_in = ent_q_ff.nxt;
         end
         ST_VTX: begin
            if (!vtx_q_ff.vis) begin
               // descend: mark the child, push the parent frame
               vtx_we     = 1'b1;
               vtx_waddr  = u_ff;
               vtx_wdata  = '{vis: 1'b1, ord: VW'(order_ff), low: VW'(order_ff),
                              par: cur_v_ff};
               stk_we     = 1'b1;
               stk_waddr  = sp_ff;
               stk_wdata  = '{v: cur_v_ff, c: cur_c_ff};
               sp_in      = sp_ff + VW'(1);
               order_in   = order_ff + CW'(1);
               seen_in    = seen_ff + CW'(1);
               cur_v_in   = u_ff;
               cur_ord_in = VW'(order_ff);
               cur_low_in = VW'(order_ff);
               cur_par_in = cur_v_ff;
               head_re    = 1'b1;
               head_raddr = u_ff;
            end else begin
               if (cur_v_ff != '0) begin
                  if (vtx_q_ff.ord < cur_ord_ff && u_ff != cur_par_ff) begin
                     // back edge
                     if (cur_low_ff > vtx_q_ff.ord) begin
                        low_upd = 1'b1;
                        new_low = vtx_q_ff.ord;
                     end
                  end else if (vtx_q_ff.ord > cur_ord_ff && vtx_q_ff.par == cur_v_ff) begin
                     // returned tree child
                     if (cur_low_ff > vtx_q_ff.low) begin
                        low_upd = 1'b1;
                        new_low = vtx_q_ff.low;
                     end
                  end
               end
               if (low_upd) begin
                  cur_low_in = new_low;
                  vtx_we     = 1'b1;
                  vtx_waddr  = cur_v_ff;
                  vtx_wdata  = '{vis: 1'b1, ord: cur_ord_ff, low: new_low, par: cur_par_ff};
               end
               cur_c_in = nx_ff;
            end
         end
         ST_POP: begin
            cur_v_in  = stk_q_ff.v;
            cur_c_in  = stk_q_ff.c;
            vtx_raddr = stk_q_ff.v;
         end
         ST_POPV: begin
            cur_ord_in = vtx_q_ff.ord;
            cur_low_in = vtx_q_ff.low;
            cur_par_in = vtx_q_ff.par;
         end
         ST_FIN_RD: begin
            vtx_raddr = VW'(fin_i_ff);
         end
         ST_FIN_REC: begin
            if (vtx_q_ff.par == '0) begin
               if (kid_ff) bic_in = 1'b0;
               kid_in   = 1'b1;
               fin_i_in = fin_i_ff + CW'(1);
            end else begin
               fin_low_in = vtx_q_ff.low;
               vtx_raddr  = vtx_q_ff.par;
            end
         end
         ST_FIN_PAR: begin
            if (fin_low_ff >= vtx_q_ff.ord) bic_in = 1'b0;
            fin_i_in = fin_i_ff + CW'(1);
         end
         ST_RESULT: begin
            rsp_valid_in = 1'b1;
            total_in     = '0;
            drop_in      = STATUS_OK;
            clr_idx_in   = '0;
         end
         default: begin
         end
      endcase
   end

   // ---- memories ----
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_waddr] <= head_wdata;
      head_q_ff <= head_mem[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
      ent_q_ff <= ent_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (vtx_we) vtx_mem[vtx_waddr] <= vtx_wdata;
      vtx_q_ff <= vtx_mem[vtx_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
      stk_q_ff <= stk_mem[stk_raddr];
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         vc_ff        <= VC_W'(1);
         total_ff     <= '0;
         drop_ff      <= STATUS_OK;
         clr_idx_ff   <= '0;
         ld_last_ff   <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_en) vc_ff <= csr_vertex_count;
         total_ff     <= total_in;
         drop_ff      <= drop_in;
         clr_idx_ff   <= clr_idx_in;
         ld_last_ff   <= ld_last_in;
         fwd_hit_ff   <= head_re && head_we && (head_raddr == head_waddr);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      fwd_data_ff <= head_wdata;
      ld_a_ff     <= ld_a_in;
      ld_b_ff     <= ld_b_in;
      cur_v_ff    <= cur_v_in;
      cur_c_ff    <= cur_c_in;
      cur_ord_ff  <= cur_ord_in;
      cur_low_ff  <= cur_low_in;
      cur_par_ff  <= cur_par_in;
      sp_ff       <= sp_in;
      order_ff    <= order_in;
      seen_ff     <= seen_in;
      u_ff        <= u_in;
      nx_ff       <= nx_in;
      fin_i_ff    <= fin_i_in;
      fin_low_ff  <= fin_low_in;
      kid_ff      <= kid_in;
      conn_ff     <= conn_in;
      bic_ff      <= bic_in;
      if (rsp_valid_in) begin
         rsp_conn_ff   <= conn_ff;
         rsp_bic_ff    <= bic_ff;
         rsp_status_ff <= drop_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_connected   = rsp_conn_ff;
   assign rsp_biconnected = rsp_bic_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   // a result strobe follows the result state and nothing else
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_RESULT))
      else $error("result strobe without result state");

   a_bic_conn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_conn_ff || !rsp_bic_ff))
      else $error("biconnected reported on a disconnected graph");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (seen_ff <= n_eff))
      else $error("more vertices reached than exist");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= 32'(MAX_EDGES))
      else $error("edge store overfilled");
`endif

endmodule
